// ----- hw/rtl/int16_int4_scaled_dot_product_macros.svh -----
// assertion macros shared by the dot product modules
`ifndef INT16_INT4_SCALED_DOT_PRODUCT_MACROS_SVH
`define INT16_INT4_SCALED_DOT_PRODUCT_MACROS_SVH

// same-cycle implication, disabled during reset
`define I16I4SDP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define I16I4SDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/i16i4sdp_pkg.sv -----
// shared types and constants of the int16 x int4 scaled dot product
`timescale 1ns / 1ps

package i16i4sdp_pkg;

  // field widths
  localparam int ACT_W       = 16;
  localparam int WGT_W       = 4;
  localparam int SCALE_W     = 16;
  localparam int ACC_W       = 64;
  localparam int HALF_W      = ACC_W / 2;
  localparam int SHIFT_W     = 6;
  localparam int PROD_W      = ACT_W + WGT_W;
  localparam int GRP_W       = PROD_W + SCALE_W;
  localparam int PART_W      = HALF_W + SCALE_W;
  localparam int IN_FIELDS_W = ACT_W + WGT_W + SCALE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int RESULT_WIDTH_DEF = 28;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SHIFT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MODE   = 1'b0,
    REG_SHIFT_AMOUNT = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_GROUP,
    S_ACCUM,
    S_SCALE_LO,
    S_SCALE_HI,
    S_COMBINE,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul_act;
    logic mul_group;
    logic accumulate;
    logic scale_lo;
    logic scale_hi;
    logic combine;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic can_load;
  } sts_t;

endpackage

// ----- hw/rtl/i16i4sdp_ctrl.sv -----
// controller state machine sequencing one element at a time
`timescale 1ns / 1ps
`include "int16_int4_scaled_dot_product_macros.svh"

module i16i4sdp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output i16i4sdp_pkg::cmd_t  cmd,
  input  i16i4sdp_pkg::sts_t  sts
);
  import i16i4sdp_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_PROD;
      end
      S_PROD:     state_next = S_GROUP;
      S_GROUP:    state_next = S_ACCUM;
      S_ACCUM: begin
        state_next = sts.last ? S_SCALE_LO : S_IDLE;
      end
      S_SCALE_LO: state_next = S_SCALE_HI;
      S_SCALE_HI: state_next = S_COMBINE;
      S_COMBINE:  state_next = S_FINISH;
      S_FINISH: begin
        if (sts.can_load) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_PROD:     cmd.mul_act    = 1'b1;
      S_GROUP:    cmd.mul_group  = 1'b1;
      S_ACCUM:    cmd.accumulate = 1'b1;
      S_SCALE_LO: cmd.scale_lo   = 1'b1;
      S_SCALE_HI: cmd.scale_hi   = 1'b1;
      S_COMBINE:  cmd.combine    = 1'b1;
      S_FINISH:   cmd.finish     = sts.can_load;
      default:    cmd            = '0;
    endcase
  end

  // checks
  `I16I4SDP_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == S_PROD)
  `I16I4SDP_ASSERT_NOW(a_finish_has_room, clk, rst, cmd.finish, sts.can_load)
  `I16I4SDP_ASSERT_NEXT(a_finish_to_idle, clk, rst, cmd.finish, state == S_IDLE)

endmodule

// ----- hw/rtl/i16i4sdp_dp.sv -----
// datapath: multipliers, accumulator, final scaling and output register
`timescale 1ns / 1ps
`include "int16_int4_scaled_dot_product_macros.svh"

module i16i4sdp_dp #(
  parameter int RESULT_WIDTH = i16i4sdp_pkg::RESULT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [i16i4sdp_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [RESULT_WIDTH-1:0]                out_data,
  input  logic                                   cfg_valid,
  input  logic [i16i4sdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i16i4sdp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  i16i4sdp_pkg::cmd_t                     cmd,
  output i16i4sdp_pkg::sts_t                     sts
);
  import i16i4sdp_pkg::*;

  // configuration registers
  logic               scale_mode;
  logic [SHIFT_W-1:0] shift_amount;

  // captured element
  logic [ACT_W-1:0]   act_q;
  logic [WGT_W-1:0]   wgt_q;
  logic [SCALE_W-1:0] scale_q;
  logic               last_q;

  // pipeline values
  logic signed [PROD_W-1:0] prod_q;
  logic signed [GRP_W-1:0]  grp_q;
  logic [ACC_W-1:0]         acc;
  logic [PART_W-1:0]        part_lo;
  logic [HALF_W-1:0]        part_hi;
  logic [ACC_W-1:0]         sum_q;

  logic signed [PROD_W-1:0] act_ext;
  logic signed [PROD_W-1:0] wgt_ext;
  logic signed [GRP_W-1:0]  prod_ext;
  logic signed [GRP_W-1:0]  scale_ext;
  logic signed [GRP_W-1:0]  grp_next;
  logic [PART_W-1:0]        part_lo_next;
  logic [PART_W-1:0]        hi_full;
  logic [ACC_W-1:0]         round_term;
  logic [ACC_W-1:0]         sum_next;
  logic signed [ACC_W-1:0]  shifted;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode   <= 1'b0;
      shift_amount <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE_MODE:   scale_mode   <= cfg_data[0];
        REG_SHIFT_AMOUNT: shift_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the element fields on an input transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= s_tdata[ACT_W-1:0];
      wgt_q   <= s_tdata[ACT_W+WGT_W-1:ACT_W];
      scale_q <= s_tdata[IN_FIELDS_W-1:ACT_W+WGT_W];
      last_q  <= s_tlast;
    end
  end

  // activation times weight
  assign act_ext = {{(PROD_W-ACT_W){act_q[ACT_W-1]}}, act_q};
  assign wgt_ext = {{(PROD_W-WGT_W){wgt_q[WGT_W-1]}}, wgt_q};

  // optional group scale on the registered product
  assign prod_ext  = {{(GRP_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign scale_ext = {{(GRP_W-SCALE_W){scale_q[SCALE_W-1]}}, scale_q};
  assign grp_next  = scale_mode ? (prod_ext * scale_ext) : prod_ext;

  // per-tensor scale, split into two 32 x 16 partial products
  assign part_lo_next = PART_W'(acc[HALF_W-1:0]) * PART_W'(scale_q);
  assign hi_full      = PART_W'(acc[ACC_W-1:HALF_W]) * PART_W'(scale_q);

  // combine partials and add the rounding half lsb in per-tensor mode; group mode passes the accumulator through
  assign round_term = (shift_amount != '0) ?
                      (ACC_W'(1) << (shift_amount - SHIFT_W'(1))) : '0;
  assign sum_next   = scale_mode ? acc :
                      (ACC_W'(part_lo) + {part_hi, {HALF_W{1'b0}}} + round_term);

  // arithmetic shift of the final sum
  assign shifted = $signed(sum_q) >>> shift_amount;

  // product pipeline and final scaling registers
  always_ff @(posedge clk) begin
    if (cmd.mul_act)   prod_q  <= act_ext * wgt_ext;
    if (cmd.mul_group) grp_q   <= grp_next;
    if (cmd.scale_lo)  part_lo <= part_lo_next;
    if (cmd.scale_hi)  part_hi <= hi_full[HALF_W-1:0];
    if (cmd.combine)   sum_q   <= sum_next;
  end

  // wrapping accumulator, cleared when a result is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.finish) begin
      acc <= '0;
    end else if (cmd.accumulate) begin
      acc <= acc + {{(ACC_W-GRP_W){grp_q[GRP_W-1]}}, grp_q};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= shifted[RESULT_WIDTH-1:0];
  end

  // status back to the controller
  assign sts.last     = last_q;
  assign sts.can_load = !m_tvalid || m_tready;

  // checks
  `I16I4SDP_ASSERT_NOW(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `I16I4SDP_ASSERT_NEXT(a_finish_clears, clk, rst, cmd.finish, acc == '0)
  `I16I4SDP_ASSERT_NEXT(a_finish_presents, clk, rst, cmd.finish, m_tvalid)

endmodule

// ----- hw/rtl/int16_int4_scaled_dot_product.sv -----
// Streaming int16 x int4 dot product with per-tensor or per-group scaling.
//
// Input stream s_*: one activation / weight / scale element per transaction,
// s_tlast marks the final element of a vector. Output stream m_*: one
// RESULT_WIDTH-bit result per vector, issued after the element with tlast.
// Configuration channel cfg_*: index 0 scale_mode, index 1 shift_amount,
// always ready; write only while the block is idle.
// Each element is captured on acceptance, then goes through the activation x
// weight multiply, the group-scale multiply and the accumulate before the next
// element is accepted; the controller runs one element at a time.
// A last element then goes through the two 32 x 16 partial products of the
// per-tensor scale, the combine with rounding and the shift into the output
// register, which waits until that register can take the result.
// The output register holds a result until taken; the next vector can be
// accumulated meanwhile, and only its own final step waits for the register.
// Reset clears the accumulator, both configuration registers and m_tvalid.
`timescale 1ns / 1ps

module int16_int4_scaled_dot_product #(
  parameter int RESULT_WIDTH = i16i4sdp_pkg::RESULT_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // activation [15:0], weight_nibble [19:16], scale_raw [35:20], zero pad
  input  logic [i16i4sdp_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                     s_tlast,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // dot_result [RESULT_WIDTH-1:0], zero pad to whole bytes
  output logic [((RESULT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [i16i4sdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i16i4sdp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import i16i4sdp_pkg::*;

  localparam int OUT_TDATA_W = ((RESULT_WIDTH + 7) / 8) * 8;

  cmd_t                    cmd;
  sts_t                    sts;
  logic [RESULT_WIDTH-1:0] out_data;

  // configuration writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencer
  i16i4sdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic and output register
  i16i4sdp_dp #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // zero-pad the result to whole bytes
  assign m_tdata = OUT_TDATA_W'(out_data);

endmodule
